// ----- hw/rtl/pgh_pkg.sv -----
// shared types, constants and the grid size function of the position grid histogram
// no dependencies
package pgh_pkg;

   localparam int MaxSeries   = 32;
   localparam int MaxColumns  = 32;
   localparam int MaxRows     = 32;
   localparam int Teams       = 2;
   localparam int CountBits   = 16;
   localparam int PosBits     = 24;
   localparam int RegBits     = 24;
   localparam int GridBits    = 6;
   localparam int SumBits     = 20;
   localparam int Cells       = MaxColumns * MaxRows;
   localparam int CellBits    = $clog2(Cells);
   localparam int SeriesBits  = $clog2(MaxSeries);
   localparam int SeriesDepth = MaxSeries * Cells;
   localparam int SeriesAddrBits = $clog2(SeriesDepth);
   localparam int TeamDepth   = Teams * Cells;
   localparam int TeamAddrBits = $clog2(TeamDepth);
   localparam int DiffBits    = RegBits + 1;
   localparam int ProdBits    = DiffBits + GridBits;
   localparam int DivSteps    = 6;
   localparam int ClearBits   = SeriesAddrBits;

   localparam logic [GridBits-1:0] DefColumns = GridBits'(18);
   localparam logic [GridBits-1:0] DefRows    = GridBits'(24);

   localparam logic [2:0] RegMinX = 3'd0;
   localparam logic [2:0] RegMaxX = 3'd1;
   localparam logic [2:0] RegMinZ = 3'd2;
   localparam logic [2:0] RegMaxZ = 3'd3;
   localparam logic [2:0] RegCols = 3'd4;
   localparam logic [2:0] RegRows = 3'd5;

   typedef struct packed {
      logic [4:0]  series_id;
      logic        team_id;
      logic        is_player;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_z;
   } req_type;

   typedef struct packed {
      logic        in_field;
      logic [4:0]  cell_column;
      logic [4:0]  cell_row;
      logic [9:0]  cell_index;
      logic [15:0] series_count;
      logic [19:0] team_cell_sum;
      logic [19:0] team_max;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIV_X, ST_DIV_Z, ST_ADDR, ST_READ,
      ST_UPDATE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start_x;
      logic div_start_z;
      logic div_step;
      logic clear_step;
      logic mem_read;
      logic mem_write;
      logic out_load;
      logic out_empty;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic div_done;
      logic clear_done;
   } status_type;

   function automatic logic [GridBits-1:0] grid_size(input logic [GridBits-1:0] raw,
                                                       input logic [GridBits-1:0] def,
                                                       input logic [GridBits-1:0] max);
      logic [GridBits-1:0] n;
      n = (raw == '0) ? def : raw;
      if (n > max) n = max;
      return n;
   endfunction

endpackage

// ----- hw/rtl/pgh_ram.sv -----
// generic single port ram with registered read
// no dependencies
module pgh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_ff <= mem_ff[addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- hw/rtl/pgh_datapath.sv -----
// datapath: config registers, bounds check, shared restoring divider, stores, result register
// depends on pgh_pkg and pgh_ram
module pgh_datapath import pgh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_write_data,
   input  req_type      req_data,
   input  cmd_type      cmd,
   output status_type   status,
   output rsp_type      rsp_data
);
   logic signed [23:0] min_x_ff, max_x_ff, min_z_ff, max_z_ff;
   logic [GridBits-1:0] cols_ff, rows_ff;
   req_type req_ff;
   logic [GridBits-1:0] ncols, nrows;
   logic signed [DiffBits-1:0] span_x, span_z, diff_x, diff_z;
   logic ok_x, ok_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= -24'sd11520; max_x_ff <= 24'sd11520;
         min_z_ff <= -24'sd15360; max_z_ff <= 24'sd15360;
         cols_ff  <= DefColumns;  rows_ff  <= DefRows;
      end else if (csr_write_en) begin
         unique case (csr_index)
            RegMinX: min_x_ff <= csr_write_data;
            RegMaxX: max_x_ff <= csr_write_data;
            RegMinZ: min_z_ff <= csr_write_data;
            RegMaxZ: max_z_ff <= csr_write_data;
            RegCols: cols_ff  <= csr_write_data[GridBits-1:0];
            RegRows: rows_ff  <= csr_write_data[GridBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   assign ncols  = grid_size(cols_ff, DefColumns, GridBits'(MaxColumns));
   assign nrows  = grid_size(rows_ff, DefRows, GridBits'(MaxRows));
   assign span_x = DiffBits'(max_x_ff) - DiffBits'(min_x_ff);
   assign span_z = DiffBits'(max_z_ff) - DiffBits'(min_z_ff);
   assign diff_x = DiffBits'(req_ff.pos_x) - DiffBits'(min_x_ff);
   assign diff_z = DiffBits'(req_ff.pos_z) - DiffBits'(min_z_ff);
   assign ok_x   = (span_x > 0) && (diff_x >= 0) && (diff_x <= span_x);
   assign ok_z   = (span_z > 0) && (diff_z >= 0) && (diff_z <= span_z);
   assign status.in_range = ok_x && ok_z;

   // restoring divider: quotient has at most 6 bits since diff <= span
   logic [ProdBits-1:0] num_ff, num_in;
   logic [DiffBits-1:0] den_ff, den_in;
   logic [ProdBits:0]   rem_ff, rem_in, trial;
   logic [GridBits-1:0] quo_ff, quo_in;
   logic [4:0]          step_ff, step_in;
   logic [GridBits-1:0] col_ff, row_ff, row_bin;
   logic [ProdBits:0]   shifted;

   assign shifted = {rem_ff[ProdBits-1:0], num_ff[ProdBits-1]};
   assign trial   = shifted - (ProdBits+1)'(den_ff);

   // diff*n goes through the loop one bit per step, ProdBits steps in all
   always_comb begin
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      step_in = step_ff;
      if (cmd.div_start_x || cmd.div_start_z) begin
         if (cmd.div_start_x) begin
            num_in = ProdBits'(diff_x) * ProdBits'(ncols);
            den_in = span_x;
         end else begin
            num_in = ProdBits'(diff_z) * ProdBits'(nrows);
            den_in = span_z;
         end
         rem_in = '0; quo_in = '0; step_in = '0;
      end else if (cmd.div_step) begin
         num_in = num_ff << 1;
         if (!trial[ProdBits]) rem_in = trial;
         else rem_in = shifted;
         quo_in = {quo_ff[GridBits-2:0], ~trial[ProdBits]};
         step_in = step_ff + 5'd1;
      end
   end
   assign status.div_done = (step_ff == 5'(ProdBits));
   assign row_bin = (quo_ff >= nrows) ? nrows - 1'b1 : quo_ff;

   always_ff @(posedge clock) begin
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in;
      quo_ff <= quo_in; step_ff <= step_in;
      if (cmd.div_start_z) col_ff <= (quo_ff >= ncols) ? ncols - 1'b1 : quo_ff;
      if (cmd.mem_read)    row_ff <= row_bin;
   end

   // stores and clearing sweep
   logic [ClearBits:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step && !status.clear_done) clr_ff <= clr_ff + 1'b1;
   end
   assign status.clear_done = clr_ff[ClearBits];

   logic [CellBits-1:0] cell_ff;
   logic [SeriesAddrBits-1:0] s_addr;
   logic [TeamAddrBits-1:0] t_addr;
   logic [CountBits-1:0] cnt_rd, cnt_new;
   logic [SumBits-1:0] sum_rd, sum_new, tmax_new;
   logic [SumBits-1:0] tmax_ff [Teams];
   logic t_sel;

   always_ff @(posedge clock) begin
      if (cmd.mem_read)
         cell_ff <= CellBits'(row_bin) * CellBits'(ncols) + CellBits'(col_ff);
   end

   assign t_sel  = req_ff.team_id;
   assign s_addr = cmd.clear_step ? clr_ff[SeriesAddrBits-1:0]
                 : {req_ff.series_id, cell_ff};
   assign t_addr = cmd.clear_step ? clr_ff[TeamAddrBits-1:0] : {t_sel, cell_ff};
   assign cnt_new = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
   assign sum_new = !req_ff.is_player ? sum_rd : ((&sum_rd) ? sum_rd : sum_rd + 1'b1);
   assign tmax_new = (req_ff.is_player && sum_new > tmax_ff[t_sel]) ? sum_new : tmax_ff[t_sel];

   pgh_ram #(.Width(CountBits), .Depth(SeriesDepth)) u_series (
      .clock, .wr_en(cmd.clear_step || cmd.mem_write), .addr(s_addr),
      .wr_data(cmd.clear_step ? '0 : cnt_new), .rd_data(cnt_rd));
   pgh_ram #(.Width(SumBits), .Depth(TeamDepth)) u_team (
      .clock, .wr_en((cmd.clear_step && !clr_ff[TeamAddrBits]) || cmd.mem_write),
      .addr(t_addr), .wr_data(cmd.clear_step ? '0 : sum_new), .rd_data(sum_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < Teams; t++) tmax_ff[t] <= '0;
      end else if (cmd.mem_write) tmax_ff[t_sel] <= tmax_new;
   end

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_empty) rsp_ff <= '0;
      else if (cmd.out_load) begin
         rsp_ff.in_field      <= 1'b1;
         rsp_ff.cell_column   <= 5'(col_ff);
         rsp_ff.cell_row      <= 5'(row_ff);
         rsp_ff.cell_index    <= cell_ff;
         rsp_ff.series_count  <= cnt_new;
         rsp_ff.team_cell_sum <= sum_new;
         rsp_ff.team_max      <= tmax_new;
      end
   end
   assign rsp_data = rsp_ff;
endmodule

// ----- hw/rtl/pgh_ctrl.sv -----
// controller state machine sequencing clear, divide, memory update and output
// depends on pgh_pkg
module pgh_ctrl import pgh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // the result register takes a new item once the waiting one has gone
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.in_range) state_in = ST_DIV_X;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_DIV_X:  if (status.div_done) state_in = ST_DIV_Z;
         ST_DIV_Z:  if (status.div_done) state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE:   cmd.load = req_valid;
         ST_CHECK: begin
            cmd.div_start_x = status.in_range;
            cmd.out_empty = !status.in_range && out_free;
         end
         ST_DIV_X: begin
            cmd.div_step = !status.div_done;
            cmd.div_start_z = status.div_done;
         end
         ST_DIV_Z:  cmd.div_step = !status.div_done;
         ST_ADDR:   cmd.mem_read = 1'b1;
         ST_READ:   ;
         // the store is written once, when the result register is free
         ST_UPDATE: begin
            cmd.mem_write = out_free;
            cmd.out_load = out_free;
         end
         ST_OUT:    ;
         default:   ;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load || cmd.out_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready) else $error("ready during clear");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |=> !cmd.mem_write) else $error("double write");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE) else $error("load outside idle");
`endif
endmodule

// ----- hw/rtl/position_grid_histogram_core.sv -----
// Position grid histogram: bins one position sample per item and updates
// per-entity and per-team cell counters; built from pgh_pkg, pgh_ctrl and
// pgh_datapath. After reset a clearing sweep zeroes the stores before the
// first item is taken. An item in the field goes through the check, the
// shared restoring divider, which runs 31 steps for each axis, and the
// address, read and update states, where its result is loaded; the next
// item is taken only once the receiver has taken that result. An item
// outside the field gets an empty result from the check state. After an
// out-of-field result held back by the receiver, the next item stalls at
// its check or before its store update. Items are handled one at a time.
module position_grid_histogram_core import pgh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data
);
   cmd_type    cmd;
   status_type status;

   pgh_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
                    .status, .cmd);
   pgh_datapath u_dp (.clock, .reset, .csr_write_en, .csr_index, .csr_write_data,
                      .req_data, .cmd, .status, .rsp_data);
endmodule
